FILE: rtl/htld_pkg.sv
package htld_pkg;

    localparam int NODE_COUNT_DFLT = 512;

    localparam logic [1:0] OP_LOAD_BIT    = 2'd0;
    localparam logic [1:0] OP_LOAD_SYMBOL = 2'd1;
    localparam logic [1:0] OP_DECODE_BIT  = 2'd2;
    localparam logic [1:0] OP_END_MESSAGE = 2'd3;

    localparam logic [1:0] KIND_BYTE    = 2'd0;
    localparam logic [1:0] KIND_FULL    = 2'd1;
    localparam logic [1:0] KIND_MISSING = 2'd2;

    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_DOLLAR  = 8'd36;
    localparam logic [7:0] CH_PERCENT = 8'd37;

    typedef struct packed {
        logic [1:0] operation;
        logic       code_bit;
        logic [7:0] symbol_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] result_kind;
        logic       last_of_run;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD_READ,
        ST_LOAD_CHECK,
        ST_LOAD_LINK,
        ST_SYMBOL,
        ST_DEC_READ,
        ST_DEC_CHECK,
        ST_DEC_LEAF,
        ST_END_READ,
        ST_END_FLUSH,
        ST_END_NEWLINE
    } state_t;

    typedef enum logic [1:0] {
        RD_LOAD,
        RD_DECODE,
        RD_CHILD
    } rd_src_t;

    typedef enum logic [1:0] {
        EMIT_FULL,
        EMIT_MISSING,
        EMIT_SYM,
        EMIT_NL
    } emit_src_t;

    typedef struct packed {
        logic      capture;
        logic      rd_en;
        rd_src_t   rd_src;
        logic      clear_node;
        logic      link_node;
        logic      store_sym;
        logic      load_follow;
        logic      dec_child;
        logic      dec_root;
        logic      emit;
        emit_src_t emit_src;
        logic      emit_last;
    } ctrl_cmd_t;

    typedef struct packed {
        logic child_zero;
        logic table_full;
        logic leaf;
        logic dcur_root;
        logic sym_is_nl;
        logic last_is_nl;
    } dp_status_t;

    function automatic logic [7:0] map_symbol(input logic [7:0] raw);
        logic [7:0] v;
        v = raw;
        if (raw == CH_PERCENT)
        begin
            v = CH_SPACE;
        end
        else if (raw == CH_DOLLAR)
        begin
            v = CH_NEWLINE;
        end
        return v;
    endfunction

endpackage

FILE: rtl/huffman_tree_load_and_decode_unit.sv
// Huffman tree load and decode unit. One transaction is accepted at a rising
// edge where start is high and busy is low; the fields of item are sampled
// there. Load-bit transactions walk the tree from the load cursor and allocate
// a child node when the selected one is missing, or report a full table;
// load-symbol stores a byte (percent as space, dollar as newline) at the
// current node and returns the load walk to the root. Decode-bit steps the
// decode cursor and reports the leaf byte, or a missing result when the
// selected child is missing; end-of-message flushes an unfinished code, then
// adds a newline unless the last reported byte already was one. Results come
// out on result with strobe high for exactly one cycle and cannot be held
// off: the receiver must take every strobed result. last_of_run marks the
// final result of a transaction; a transaction can produce zero, one or two
// results. A load bit reads the node, checks the child and may link a new
// node; a decode bit reads the node, checks the child and may test it for a
// leaf; an end of message may flush before the newline check; a load symbol
// is a single store. Each step reads the node tables through their registered
// read port before the next address is known; a new node is cleared in the
// cycle that finds the child missing and linked into the parent in the next.
// The root node is held in flops, so the block is ready right after reset with
// no clearing pass. Results are registered and may overlap the next accept.
module huffman_tree_load_and_decode_unit
    import htld_pkg::*;
#(
    parameter int NODE_COUNT = NODE_COUNT_DFLT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  in_item_t  item,
    output out_item_t result,
    output logic      strobe
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // sequence the table walk for each transaction
    htld_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (item.operation),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy)
    );

    // node tables, cursors and the result register
    htld_datapath #(.NODE_COUNT(NODE_COUNT)) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .status (status),
        .result (result),
        .strobe (strobe)
    );

endmodule

FILE: rtl/htld_ram.sv
module htld_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/htld_ctrl.sv
module htld_ctrl
    import htld_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] operation,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd,
    output logic       busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (operation)
                        OP_LOAD_BIT:    state_next = ST_LOAD_READ;
                        OP_LOAD_SYMBOL: state_next = ST_SYMBOL;
                        OP_DECODE_BIT:  state_next = ST_DEC_READ;
                        OP_END_MESSAGE: state_next = ST_END_READ;
                        default:        state_next = ST_IDLE;
                    endcase
                end
            end
            ST_LOAD_READ:  state_next = ST_LOAD_CHECK;
            ST_LOAD_CHECK:
            begin
                if (status.child_zero && !status.table_full)
                begin
                    state_next = ST_LOAD_LINK;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_LOAD_LINK:  state_next = ST_IDLE;
            ST_SYMBOL:     state_next = ST_IDLE;
            ST_DEC_READ:   state_next = ST_DEC_CHECK;
            ST_DEC_CHECK:  state_next = status.child_zero ? ST_IDLE : ST_DEC_LEAF;
            ST_DEC_LEAF:   state_next = ST_IDLE;
            ST_END_READ:   state_next = status.dcur_root ? ST_END_NEWLINE : ST_END_FLUSH;
            ST_END_FLUSH:  state_next = ST_END_NEWLINE;
            ST_END_NEWLINE: state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd.capture     = 1'b0;
        cmd.rd_en       = 1'b0;
        cmd.rd_src      = RD_LOAD;
        cmd.clear_node  = 1'b0;
        cmd.link_node   = 1'b0;
        cmd.store_sym   = 1'b0;
        cmd.load_follow = 1'b0;
        cmd.dec_child   = 1'b0;
        cmd.dec_root    = 1'b0;
        cmd.emit        = 1'b0;
        cmd.emit_src    = EMIT_SYM;
        cmd.emit_last   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.capture = start;
            end
            ST_LOAD_READ:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_src = RD_LOAD;
            end
            ST_LOAD_CHECK:
            begin
                if (!status.child_zero)
                begin
                    cmd.load_follow = 1'b1;
                end
                else if (status.table_full)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_src  = EMIT_FULL;
                    cmd.emit_last = 1'b1;
                end
                else
                begin
                    cmd.clear_node = 1'b1;
                end
            end
            ST_LOAD_LINK:
            begin
                cmd.link_node = 1'b1;
            end
            ST_SYMBOL:
            begin
                cmd.store_sym = 1'b1;
            end
            ST_DEC_READ:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_src = RD_DECODE;
            end
            ST_DEC_CHECK:
            begin
                if (status.child_zero)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_src  = EMIT_MISSING;
                    cmd.emit_last = 1'b1;
                    cmd.dec_root  = 1'b1;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_src = RD_CHILD;
                end
            end
            ST_DEC_LEAF:
            begin
                if (status.leaf)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_src  = EMIT_SYM;
                    cmd.emit_last = 1'b1;
                    cmd.dec_root  = 1'b1;
                end
                else
                begin
                    cmd.dec_child = 1'b1;
                end
            end
            ST_END_READ:
            begin
                cmd.rd_en  = !status.dcur_root;
                cmd.rd_src = RD_DECODE;
            end
            ST_END_FLUSH:
            begin
                cmd.emit      = 1'b1;
                cmd.emit_src  = EMIT_SYM;
                cmd.emit_last = status.sym_is_nl;
                cmd.dec_root  = 1'b1;
            end
            ST_END_NEWLINE:
            begin
                cmd.emit      = !status.last_is_nl;
                cmd.emit_src  = EMIT_NL;
                cmd.emit_last = 1'b1;
            end
            default:
            begin
                cmd.capture = 1'b0;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && start) |=> (state_reg != ST_IDLE))
        else $error("accepted transaction did not start work");

    a_alloc_links: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_node |=> (state_reg == ST_LOAD_LINK))
        else $error("node cleared without link");

    a_flush_then_newline: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_END_FLUSH) |=> (state_reg == ST_END_NEWLINE))
        else $error("flush not followed by newline check");

endmodule

FILE: rtl/htld_datapath.sv
module htld_datapath
    import htld_pkg::*;
#(
    parameter int NODE_COUNT = NODE_COUNT_DFLT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  in_item_t   item,
    input  ctrl_cmd_t  cmd,
    output dp_status_t status,
    output out_item_t  result,
    output logic       strobe
);

    localparam int NW = $clog2(NODE_COUNT);
    localparam int FW = $clog2(NODE_COUNT + 1);

    // captured transaction
    logic           bit_reg;
    logic [7:0]     sym_reg;
    logic [NW-1:0]  child_reg;

    logic [FW-1:0]  next_free_reg, next_free_next;
    logic [NW-1:0]  load_cur_reg, load_cur_next;
    logic [NW-1:0]  dec_cur_reg, dec_cur_next;
    logic [7:0]     last_byte_reg, last_byte_next;

    // root entries live in flops so the tree is valid straight out of reset
    logic [NW-1:0]  root_left_reg, root_left_next;
    logic [NW-1:0]  root_right_reg, root_right_next;
    logic [7:0]     root_sym_reg, root_sym_next;
    logic           rd_root_reg;

    out_item_t      result_reg, result_next;
    logic           strobe_reg;

    logic [NW-1:0]  raddr;
    logic [NW-1:0]  ram_left_q, ram_right_q;
    logic [7:0]     ram_sym_q;
    logic [NW-1:0]  rd_left, rd_right;
    logic [7:0]     rd_sym;
    logic [NW-1:0]  child_sel;
    logic [NW-1:0]  new_node;
    logic           lcur_root;

    logic           left_we, right_we, sym_we;
    logic [NW-1:0]  left_wd, right_wd, wr_node;
    logic [7:0]     sym_wd;

    assign new_node  = next_free_reg[NW-1:0];
    assign lcur_root = (load_cur_reg == '0);

    assign rd_left   = rd_root_reg ? root_left_reg  : ram_left_q;
    assign rd_right  = rd_root_reg ? root_right_reg : ram_right_q;
    assign rd_sym    = rd_root_reg ? root_sym_reg   : ram_sym_q;
    assign child_sel = bit_reg ? rd_right : rd_left;

    always_comb
    begin
        case (cmd.rd_src)
            RD_LOAD:   raddr = load_cur_reg;
            RD_DECODE: raddr = dec_cur_reg;
            RD_CHILD:  raddr = child_sel;
            default:   raddr = '0;
        endcase
    end

    // clearing a fresh node writes all three tables at once; linking writes one, or a root flop
    assign wr_node  = cmd.clear_node ? new_node : load_cur_reg;
    assign left_we  = cmd.clear_node || (cmd.link_node && !bit_reg && !lcur_root);
    assign right_we = cmd.clear_node || (cmd.link_node && bit_reg && !lcur_root);
    assign sym_we   = cmd.clear_node || (cmd.store_sym && !lcur_root);
    assign left_wd  = cmd.clear_node ? '0 : new_node;
    assign right_wd = cmd.clear_node ? '0 : new_node;
    assign sym_wd   = cmd.clear_node ? 8'd0 : map_symbol(sym_reg);

    htld_ram #(.WIDTH(NW), .DEPTH(NODE_COUNT)) u_left_ram (
        .clk   (clk),
        .we    (left_we),
        .waddr (wr_node),
        .wdata (left_wd),
        .re    (cmd.rd_en),
        .raddr (raddr),
        .rdata (ram_left_q)
    );

    htld_ram #(.WIDTH(NW), .DEPTH(NODE_COUNT)) u_right_ram (
        .clk   (clk),
        .we    (right_we),
        .waddr (wr_node),
        .wdata (right_wd),
        .re    (cmd.rd_en),
        .raddr (raddr),
        .rdata (ram_right_q)
    );

    htld_ram #(.WIDTH(8), .DEPTH(NODE_COUNT)) u_sym_ram (
        .clk   (clk),
        .we    (sym_we),
        .waddr (wr_node),
        .wdata (sym_wd),
        .re    (cmd.rd_en),
        .raddr (raddr),
        .rdata (ram_sym_q)
    );

    always_comb
    begin
        next_free_next  = next_free_reg;
        load_cur_next   = load_cur_reg;
        dec_cur_next    = dec_cur_reg;
        root_left_next  = root_left_reg;
        root_right_next = root_right_reg;
        root_sym_next   = root_sym_reg;
        last_byte_next  = last_byte_reg;

        if (cmd.link_node)
        begin
            next_free_next = next_free_reg + 1'b1;
            load_cur_next  = new_node;
            if (lcur_root && !bit_reg)
            begin
                root_left_next = new_node;
            end
            if (lcur_root && bit_reg)
            begin
                root_right_next = new_node;
            end
        end
        if (cmd.load_follow)
        begin
            load_cur_next = child_sel;
        end
        if (cmd.store_sym)
        begin
            load_cur_next = '0;
            if (lcur_root)
            begin
                root_sym_next = map_symbol(sym_reg);
            end
        end
        if (cmd.dec_child)
        begin
            dec_cur_next = child_reg;
        end
        if (cmd.dec_root)
        begin
            dec_cur_next = '0;
        end

        result_next.last_of_run = cmd.emit_last;
        case (cmd.emit_src)
            EMIT_FULL:
            begin
                result_next.out_byte    = 8'd0;
                result_next.result_kind = KIND_FULL;
            end
            EMIT_MISSING:
            begin
                result_next.out_byte    = 8'd0;
                result_next.result_kind = KIND_MISSING;
            end
            EMIT_SYM:
            begin
                result_next.out_byte    = rd_sym;
                result_next.result_kind = KIND_BYTE;
            end
            EMIT_NL:
            begin
                result_next.out_byte    = CH_NEWLINE;
                result_next.result_kind = KIND_BYTE;
            end
            default:
            begin
                result_next.out_byte    = 8'd0;
                result_next.result_kind = KIND_BYTE;
            end
        endcase
        if (cmd.emit && result_next.result_kind == KIND_BYTE)
        begin
            last_byte_next = result_next.out_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_free_reg  <= FW'(1);
            load_cur_reg   <= '0;
            dec_cur_reg    <= '0;
            root_left_reg  <= '0;
            root_right_reg <= '0;
            root_sym_reg   <= '0;
            last_byte_reg  <= '0;
            rd_root_reg    <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            next_free_reg  <= next_free_next;
            load_cur_reg   <= load_cur_next;
            dec_cur_reg    <= dec_cur_next;
            root_left_reg  <= root_left_next;
            root_right_reg <= root_right_next;
            root_sym_reg   <= root_sym_next;
            last_byte_reg  <= last_byte_next;
            strobe_reg     <= cmd.emit;
            if (cmd.rd_en)
            begin
                rd_root_reg <= (raddr == '0);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            bit_reg <= item.code_bit;
            sym_reg <= item.symbol_byte;
        end
        if (cmd.rd_en && cmd.rd_src == RD_CHILD)
        begin
            child_reg <= child_sel;
        end
        if (cmd.emit)
        begin
            result_reg <= result_next;
        end
    end

    assign status.child_zero = (child_sel == '0);
    assign status.table_full = (next_free_reg == FW'(NODE_COUNT));
    assign status.leaf       = (rd_left == '0) && (rd_right == '0);
    assign status.dcur_root  = (dec_cur_reg == '0);
    assign status.sym_is_nl  = (rd_sym == CH_NEWLINE);
    assign status.last_is_nl = (last_byte_reg == CH_NEWLINE);

    assign result = result_reg;
    assign strobe = strobe_reg;

    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (next_free_reg <= FW'(NODE_COUNT)) && (next_free_reg != '0))
        else $error("free node count out of range");

    a_load_cur_allocated: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, load_cur_reg} < {1'b0, next_free_reg})
        else $error("load cursor points at unallocated node");

    a_dec_cur_allocated: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, dec_cur_reg} < {1'b0, next_free_reg})
        else $error("decode cursor points at unallocated node");

    a_error_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && result_reg.result_kind != KIND_BYTE) |-> (result_reg.out_byte == 8'd0))
        else $error("error result carries a byte");

endmodule
